FILE: design/l2_mac_learning_table_assert.svh
// Assertion macros for the MAC learning table.
`ifndef L2_MAC_LEARNING_TABLE_ASSERT_SVH
`define L2_MAC_LEARNING_TABLE_ASSERT_SVH

// Same-cycle implication.
`define LMT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication.
`define LMT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: design/lmt_pkg.sv
package lmt_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int NUM_DATAPATHS_DEF = 8;

  localparam logic [31:0] FLOOD_RESET = 32'hFFFF_FFFB;
  localparam logic [15:0] PRIO_RESET  = 16'd100;
  localparam logic [15:0] PRIO_MAX    = 16'hFFFF;
  localparam logic [47:0] BCAST_MAC   = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] KIND_PACKET  = 2'd0;
  localparam logic [1:0] KIND_REMOVED = 2'd1;
  localparam logic [1:0] KIND_DP_UP   = 2'd2;

  localparam logic CFG_FLOOD = 1'b0;
  localparam logic CFG_PRIO  = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_TBL  = 3'd1;
  localparam logic [2:0] ST_INCONS  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;
  localparam logic [2:0] ST_SAT     = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LAST = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

  typedef struct packed {
    logic start;
    logic rd;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [2:0]  dp;
    logic [47:0] mac;
    logic [31:0] port;
  } entry_t;

endpackage

FILE: design/l2_mac_learning_table.sv
// A request is accepted in idle, then the entry memory is scanned, one read a cycle,
// for destination, source and free slot; the exec state loads the result register once
// it is free. A new request is accepted only after that, back in idle.
// A result may wait in the output register while the next request is scanned.
// Reset (synchronous, active low) clears valid bits and datapath enables and
// loads flood code 0xFFFFFFFB and priority counter 100; entry data is not cleared.
module l2_mac_learning_table #(
  parameter int TABLE_ENTRIES = lmt_pkg::TABLE_ENTRIES_DEF,
  parameter int NUM_DATAPATHS = lmt_pkg::NUM_DATAPATHS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [2:0]  in_datapath,
  input  logic        in_table_miss,
  input  logic [31:0] in_port,
  input  logic [47:0] in_src_mac,
  input  logic [47:0] in_dst_mac,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_port,
  output logic        out_flood,
  output logic        out_install_flow,
  output logic [47:0] out_flow_mac,
  output logic [31:0] out_flow_port,
  output logic [15:0] out_flow_priority,
  output logic [2:0]  out_status
);
  import lmt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lmt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .NUM_DATAPATHS (NUM_DATAPATHS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_kind           (in_kind),
    .in_datapath       (in_datapath),
    .in_table_miss     (in_table_miss),
    .in_port           (in_port),
    .in_src_mac        (in_src_mac),
    .in_dst_mac        (in_dst_mac),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_port          (out_port),
    .out_flood         (out_flood),
    .out_install_flow  (out_install_flow),
    .out_flow_mac      (out_flow_mac),
    .out_flow_port     (out_flow_port),
    .out_flow_priority (out_flow_priority),
    .out_status        (out_status)
  );

endmodule

FILE: design/lmt_ctrl.sv
module lmt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lmt_pkg::stat_t stat,
  output lmt_pkg::cmd_t  cmd
);
  import lmt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
        if (stat.last) state_nxt = S_LAST;
      end
      S_LAST: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: design/lmt_datapath.sv
module lmt_datapath #(
  parameter int TABLE_ENTRIES = lmt_pkg::TABLE_ENTRIES_DEF,
  parameter int NUM_DATAPATHS = lmt_pkg::NUM_DATAPATHS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lmt_pkg::cmd_t  cmd,
  output lmt_pkg::stat_t stat,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [31:0]    cfg_wdata,
  input  logic [1:0]     in_kind,
  input  logic [2:0]     in_datapath,
  input  logic           in_table_miss,
  input  logic [31:0]    in_port,
  input  logic [47:0]    in_src_mac,
  input  logic [47:0]    in_dst_mac,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_port,
  output logic           out_flood,
  output logic           out_install_flow,
  output logic [47:0]    out_flow_mac,
  output logic [31:0]    out_flow_port,
  output logic [15:0]    out_flow_priority,
  output logic [2:0]     out_status
);
  import lmt_pkg::*;
  `include "l2_mac_learning_table_assert.svh"

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  entry_t mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [NUM_DATAPATHS-1:0] dp_en_r;
  logic [31:0] flood_r;
  logic [15:0] cnt_r;

  logic [1:0]  kind_r;
  logic [2:0]  dp_r;
  logic        miss_r;
  logic [31:0] port_r;
  logic [47:0] src_r, dst_r;

  logic [IW-1:0] addr_r, rd_idx_r;
  logic          pend_r;
  entry_t        rd_r;

  logic          dhit_r, shit_r, free_r;
  logic [IW-1:0] didx_r, fidx_r;
  logic [31:0]   dport_r, sport_r;

  logic        out_valid_r;
  logic [31:0] o_port_r, o_fport_r;
  logic        o_flood_r, o_inst_r;
  logic [47:0] o_fmac_r;
  logic [15:0] o_prio_r;
  logic [2:0]  o_status_r;

  logic enabled, dp_in_range, rd_vld, rd_dmatch, rd_smatch;

  always_comb begin
    enabled     = 1'b0;
    dp_in_range = 1'b0;
    for (int i = 0; i < NUM_DATAPATHS; i++) begin
      if (32'(dp_r) == i) begin
        dp_in_range = 1'b1;
        enabled     = dp_en_r[i];
      end
    end
  end

  assign rd_vld    = pend_r && valid_r[rd_idx_r] && (rd_r.dp == dp_r);
  assign rd_dmatch = rd_vld && (rd_r.mac == dst_r);
  assign rd_smatch = rd_vld && (rd_r.mac == src_r);

  assign stat.last     = (addr_r == IW'(TABLE_ENTRIES - 1));
  assign stat.out_free = !out_valid_r || out_ready;

  // Entry memory: read during the scan, write on learn.
  always_ff @(posedge clk) begin
    if (cmd.rd) rd_r <= mem[addr_r];
    if (cmd.exec && kind_r == KIND_PACKET && miss_r && enabled && src_r != BCAST_MAC
        && !shit_r && free_r) begin
      mem[fidx_r] <= '{dp: dp_r, mac: src_r, port: port_r};
    end
  end

  // Request capture and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r <= in_kind;
      dp_r   <= in_datapath;
      miss_r <= in_table_miss;
      port_r <= in_port;
      src_r  <= in_src_mac;
      dst_r  <= in_dst_mac;
    end
    rd_idx_r <= addr_r;
    if (cmd.start) begin
      addr_r <= '0;
    end else if (cmd.rd && !stat.last) begin
      addr_r <= addr_r + IW'(1);
    end
    if (rd_dmatch && !dhit_r) begin
      didx_r  <= rd_idx_r;
      dport_r <= rd_r.port;
    end
    if (rd_smatch && !shit_r) sport_r <= rd_r.port;
    if (pend_r && !valid_r[rd_idx_r] && !free_r) fidx_r <= rd_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      dhit_r <= 1'b0;
      shit_r <= 1'b0;
      free_r <= 1'b0;
    end else begin
      pend_r <= cmd.rd;
      if (cmd.start) begin
        dhit_r <= 1'b0;
        shit_r <= 1'b0;
        free_r <= 1'b0;
      end else begin
        if (rd_dmatch) dhit_r <= 1'b1;
        if (rd_smatch) shit_r <= 1'b1;
        if (pend_r && !valid_r[rd_idx_r]) free_r <= 1'b1;
      end
    end
  end

  // Apply config writes, decide, update state and load the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      dp_en_r     <= '0;
      flood_r     <= FLOOD_RESET;
      cnt_r       <= PRIO_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FLOOD: flood_r <= cfg_wdata;
          CFG_PRIO:  cnt_r   <= cfg_wdata[15:0];
          default:   ;
        endcase
      end
      if (out_ready && !cmd.exec) out_valid_r <= 1'b0;
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
        o_port_r    <= '0;
        o_flood_r   <= 1'b0;
        o_inst_r    <= 1'b0;
        o_fmac_r    <= '0;
        o_fport_r   <= '0;
        o_prio_r    <= '0;
        o_status_r  <= ST_IGNORED;
        if (kind_r == KIND_DP_UP) begin
          if (dp_in_range) begin
            for (int i = 0; i < NUM_DATAPATHS; i++) begin
              if (32'(dp_r) == i) dp_en_r[i] <= 1'b1;
            end
            o_status_r <= ST_OK;
          end
        end else if (kind_r == KIND_REMOVED) begin
          if (enabled) begin
            if (dhit_r) valid_r[didx_r] <= 1'b0;
            o_status_r <= ST_OK;
          end else begin
            o_status_r <= ST_NO_TBL;
          end
        end else if (kind_r == KIND_PACKET && miss_r) begin
          o_port_r  <= flood_r;
          o_flood_r <= 1'b1;
          if (!enabled) begin
            o_status_r <= ST_NO_TBL;
          end else begin
            o_status_r <= ST_OK;
            if (dst_r != BCAST_MAC && dhit_r) begin
              o_port_r  <= dport_r;
              o_flood_r <= 1'b0;
            end
            if (src_r == BCAST_MAC) begin
              o_status_r <= ST_IGNORED;
            end else if (shit_r) begin
              if (sport_r != port_r) o_status_r <= ST_INCONS;
            end else if (!free_r) begin
              o_status_r <= ST_FULL;
            end else begin
              valid_r[fidx_r] <= 1'b1;
              o_inst_r  <= 1'b1;
              o_fmac_r  <= src_r;
              o_fport_r <= port_r;
              if (cnt_r == PRIO_MAX) begin
                o_status_r <= ST_SAT;
                o_prio_r   <= cnt_r;
              end else begin
                cnt_r    <= cnt_r + 16'd1;
                o_prio_r <= cnt_r + 16'd1;
              end
            end
          end
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_port          = o_port_r;
  assign out_flood         = o_flood_r;
  assign out_install_flow  = o_inst_r;
  assign out_flow_mac      = o_fmac_r;
  assign out_flow_port     = o_fport_r;
  assign out_flow_priority = o_prio_r;
  assign out_status        = o_status_r;

  `LMT_ASSERT_NXT(a_exec_shows, cmd.exec, out_valid_r)
  `LMT_ASSERT_IMP(a_exec_free, cmd.exec, stat.out_free)
  `LMT_ASSERT_IMP(a_inst_status, out_valid_r && o_inst_r, o_status_r == ST_OK || o_status_r == ST_SAT)

endmodule

FILE: test/mac_table_checker.sv
module mac_table_checker
  import lmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [2:0]  in_datapath,
  input  logic        in_table_miss,
  input  logic [31:0] in_port,
  input  logic [47:0] in_src_mac,
  input  logic [47:0] in_dst_mac,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_port,
  input  logic        out_flood,
  input  logic        out_install_flow,
  input  logic [47:0] out_flow_mac,
  input  logic [31:0] out_flow_port,
  input  logic [15:0] out_flow_priority,
  input  logic [2:0]  out_status,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;

  typedef struct packed {
    logic [31:0] port;
    logic        flood;
    logic        install;
    logic [47:0] fmac;
    logic [31:0] fport;
    logic [15:0] prio;
    logic [2:0]  status;
  } verdict_t;

  verdict_t    verdicts[$];
  logic        slot_used[SLOTS];
  logic [2:0]  slot_dp[SLOTS];
  logic [47:0] slot_mac[SLOTS];
  logic [31:0] slot_port[SLOTS];
  logic        dp_on[8];
  logic [31:0] flood_code;
  logic [15:0] prio_ctr;

  function automatic int lookup(logic [2:0] dp, logic [47:0] mac);
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && slot_dp[i] == dp && slot_mac[i] == mac) return i;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < SLOTS; i++)
      if (!slot_used[i]) return i;
    return -1;
  endfunction

  function automatic verdict_t forward(logic [1:0] kind, logic [2:0] dp, logic miss,
                                       logic [31:0] ip, logic [47:0] src,
                                       logic [47:0] dst);
    verdict_t v;
    int idx;
    v = '0;
    v.status = ST_IGNORED;
    if (kind == KIND_DP_UP) begin
      dp_on[dp] = 1'b1;
      v.status = ST_OK;
    end else if (kind == KIND_REMOVED) begin
      if (dp_on[dp]) begin
        idx = lookup(dp, dst);
        if (idx >= 0) slot_used[idx] = 1'b0;
        v.status = ST_OK;
      end else begin
        v.status = ST_NO_TBL;
      end
    end else if (kind == KIND_PACKET && miss) begin
      v.port = flood_code;
      v.flood = 1'b1;
      if (!dp_on[dp]) begin
        v.status = ST_NO_TBL;
      end else begin
        v.status = ST_OK;
        if (dst != BCAST_MAC) begin
          idx = lookup(dp, dst);
          if (idx >= 0) begin
            v.port = slot_port[idx];
            v.flood = 1'b0;
          end
        end
        if (src == BCAST_MAC) begin
          v.status = ST_IGNORED;
        end else begin
          idx = lookup(dp, src);
          if (idx >= 0) begin
            if (slot_port[idx] != ip) v.status = ST_INCONS;
          end else begin
            idx = free_slot();
            if (idx < 0) begin
              v.status = ST_FULL;
            end else begin
              slot_used[idx] = 1'b1;
              slot_dp[idx] = dp;
              slot_mac[idx] = src;
              slot_port[idx] = ip;
              if (prio_ctr == PRIO_MAX) v.status = ST_SAT;
              else prio_ctr = prio_ctr + 16'd1;
              v.install = 1'b1;
              v.fmac = src;
              v.fport = ip;
              v.prio = prio_ctr;
            end
          end
        end
      end
    end
    return v;
  endfunction

  assign pending = verdicts.size();

  always @(posedge clk) begin
    verdict_t want, got;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      for (int i = 0; i < 8; i++) dp_on[i] = 1'b0;
      flood_code = FLOOD_RESET;
      prio_ctr = PRIO_RESET;
      verdicts.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FLOOD) flood_code = cfg_wdata;
        else prio_ctr = cfg_wdata[15:0];
      end
      if (in_valid && in_ready)
        verdicts.push_back(forward(in_kind, in_datapath, in_table_miss, in_port,
                                   in_src_mac, in_dst_mac));
      if (out_valid && out_ready) begin
        got = '{out_port, out_flood, out_install_flow, out_flow_mac, out_flow_port,
                out_flow_priority, out_status};
        if (verdicts.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = verdicts.pop_front();
          if (want != got) begin
            $display("%0t: mismatch port %h/%h flood %b/%b inst %b/%b fmac %h/%h",
                     $time, want.port, got.port, want.flood, got.flood,
                     want.install, got.install, want.fmac, got.fmac);
            $display("%0t:   fport %h/%h prio %h/%h status %0d/%0d (expected/actual)",
                     $time, want.fport, got.fport, want.prio, got.prio,
                     want.status, got.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: test/testbench.sv
module testbench;
  import lmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_FLOOD;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = KIND_PACKET;
  logic [2:0]  in_datapath = '0;
  logic        in_table_miss = 1'b0;
  logic [31:0] in_port = '0;
  logic [47:0] in_src_mac = '0;
  logic [47:0] in_dst_mac = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_port;
  logic        out_flood;
  logic        out_install_flow;
  logic [47:0] out_flow_mac;
  logic [31:0] out_flow_port;
  logic [15:0] out_flow_priority;
  logic [2:0]  out_status;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          calm = 1'b0;
  logic [47:0] mac_pool[16];
  logic [31:0] port_pool[4];

  localparam int LATENCY = 70;
  localparam int LIMIT = 2000000;

  always #5 clk = ~clk;

  l2_mac_learning_table dut (.*);

  mac_table_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(negedge clk)
    out_ready <= calm || ($urandom_range(99) >= 19);

  task automatic send(logic [1:0] kind, logic [2:0] dp, logic miss, logic [31:0] ip,
                      logic [47:0] src, logic [47:0] dst);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_datapath <= dp;
    in_table_miss <= miss;
    in_port <= ip;
    in_src_mac <= src;
    in_dst_mac <= dst;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [47:0] rand_mac();
    return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
  endfunction

  task automatic random_request(int pool_size);
    int r;
    logic [1:0] kind;
    logic [47:0] src, dst;
    r = $urandom_range(99);
    kind = r < 75 ? KIND_PACKET : r < 88 ? KIND_REMOVED : r < 97 ? KIND_DP_UP : KIND_UNUSED;
    src = $urandom_range(19) == 0 ? rand_mac() : mac_pool[$urandom_range(pool_size - 1)];
    dst = $urandom_range(19) == 0 ? BCAST_MAC : mac_pool[$urandom_range(pool_size - 1)];
    if ($urandom_range(29) == 0) src = BCAST_MAC;
    send(kind, $urandom_range(7), $urandom_range(9) != 0,
         $urandom_range(9) == 0 ? $urandom : port_pool[$urandom_range(3)], src, dst);
  endtask

  initial begin
    for (int i = 0; i < 16; i++) mac_pool[i] = rand_mac();
    for (int i = 0; i < 4; i++) port_pool[i] = $urandom;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(KIND_PACKET, 3'd0, 1'b1, 32'd1, 48'h1, 48'h2);
    send(KIND_REMOVED, 3'd0, 1'b0, 32'd0, 48'h0, 48'h1);
    send(KIND_DP_UP, 3'd0, 1'b0, 32'd0, 48'h0, 48'h0);
    send(KIND_DP_UP, 3'd0, 1'b0, 32'd0, 48'h0, 48'h0);
    send(KIND_DP_UP, 3'd7, 1'b0, 32'd0, 48'h0, 48'h0);
    send(KIND_PACKET, 3'd0, 1'b0, 32'd1, 48'h1, 48'h2);
    send(KIND_PACKET, 3'd0, 1'b1, 32'd1, 48'h1, 48'h2);
    send(KIND_PACKET, 3'd0, 1'b1, 32'hFFFF_FFFF, 48'h2, 48'h1);
    send(KIND_PACKET, 3'd0, 1'b1, 32'd9, 48'h1, BCAST_MAC);
    send(KIND_PACKET, 3'd0, 1'b1, 32'd0, BCAST_MAC, 48'h2);
    send(KIND_PACKET, 3'd7, 1'b1, 32'd0, 48'hFFFF_FFFF_FFFE, 48'h1);
    send(KIND_REMOVED, 3'd0, 1'b0, 32'd0, 48'h0, 48'h1);
    send(KIND_REMOVED, 3'd0, 1'b0, 32'd0, 48'h0, 48'h1);
    send(KIND_UNUSED, 3'd0, 1'b1, 32'd0, 48'h5, 48'h6);
    write_reg(CFG_PRIO, 32'hFFFE);
    write_reg(CFG_FLOOD, 32'h0);
    send(KIND_PACKET, 3'd7, 1'b1, 32'd3, 48'h10, 48'h11);
    send(KIND_PACKET, 3'd7, 1'b1, 32'd3, 48'h11, 48'h10);
    send(KIND_PACKET, 3'd7, 1'b1, 32'd3, 48'h12, 48'h99);
    for (int i = 0; i < 64; i++)
      send(KIND_PACKET, 3'd0, 1'b1, i, 48'h1000 + i, 48'h1000);
    write_reg(CFG_FLOOD, 32'hFFFF_FFFF);
    write_reg(CFG_PRIO, 32'h0);
    for (int i = 0; i < 64; i++)
      send(KIND_REMOVED, i[2:0], 1'b0, 32'd0, 48'h0, 48'h1000 + i);
    for (int i = 0; i < 40; i++)
      send(KIND_REMOVED, 3'd0, 1'b0, 32'd0, 48'h0, 48'h1000 + i);

    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CFG_FLOOD, $urandom);
      write_reg(CFG_PRIO, phase == 3 ? 32'hFFF0 : $urandom_range(65535));
      calm = phase == 2;
      for (int i = 0; i < 440; i++) random_request(phase == 1 ? 16 : 8);
    end
    calm = 1'b0;
    settle();
    if (fail_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule
